FILE: hw/rtl/xild_pkg.sv
`default_nettype none
package xild_pkg;

    // operand class bits of a table entry
    localparam logic [6:0] OPD_I8   = 7'h01;
    localparam logic [6:0] OPD_I16  = 7'h02;
    localparam logic [6:0] OPD_I32  = 7'h04;
    localparam logic [6:0] OPD_REG  = 7'h08;
    localparam logic [6:0] OPD_RM   = 7'h10;
    localparam logic [6:0] OPD_MOFS = 7'h20;
    localparam logic [6:0] OPD_LOW3 = 7'h40;
    localparam logic [6:0] OPD_RMR  = 7'h18;

    localparam logic [7:0] BYTE_ESC  = 8'h0F;
    localparam logic [7:0] BYTE_P66  = 8'h66;
    localparam logic [7:0] BYTE_P67  = 8'h67;
    localparam logic [7:0] BYTE_JREL = 8'hE9;

    localparam logic [1:0] CFG_LONG_MODE  = 2'd0;
    localparam logic [1:0] CFG_WIDE_MOFFS = 2'd1;

    // stage 1 -> stage 2: prefix scan result
    typedef struct packed {
        logic [2:0] pos;
        logic       seg;
        logic       p66;
        logic       p67;
        logic       rex;
        logic       rexw;
    } xild_pfx_t;

    // stage 2 -> stage 3: opcode match result
    typedef struct packed {
        xild_pfx_t  pfx;
        logic       hit;
        logic       twobyte;
        logic [6:0] opd;
        logic       wide;
        logic       rel;
        logic [7:0] modrm;
        logic [7:0] sib;
    } xild_match_t;

    typedef struct packed {
        logic       recognized;
        logic [3:0] prefix_flags;
        logic [1:0] opcode_length;
        logic       has_modrm;
        logic       has_sib;
        logic [2:0] disp_length;
        logic [3:0] imm_length;
        logic       disp_needs_fixup;
        logic [3:0] total_length;
    } xild_res_t;

    function automatic logic is_seg(input logic [7:0] b);
        return b == 8'h2E || b == 8'h36 || b == 8'h26 || b == 8'h64 || b == 8'h65;
    endfunction

    // opcode lookup: returns hit, wide flag and operand class
    function automatic logic [8:0] op_lookup(input logic twobyte, input logic [7:0] op,
                                             input logic [7:0] op2, input logic [2:0] reg_f,
                                             input logic lm);
        logic       h;
        logic [6:0] o;
        logic       w;
        h = 1'b1;
        o = '0;
        w = 1'b0;
        if (twobyte) begin
            h = (op2 == 8'hB6) || (op2 == 8'hB7);
            o = OPD_RMR;
        end else begin
            unique case (op) inside
                8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0A, 8'h0B,
                8'h20, 8'h21, 8'h22, 8'h23, 8'h28, 8'h29, 8'h2A, 8'h2B,
                8'h30, 8'h31, 8'h32, 8'h33, 8'h38, 8'h39, 8'h3A, 8'h3B,
                8'h8D, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E: o = OPD_RMR;
                8'h04, 8'h0C, 8'h24, 8'h2C, 8'h34, 8'h3C, 8'h6A: o = OPD_I8;
                8'h05, 8'h0D, 8'h25, 8'h2D, 8'h35, 8'h3D, 8'h68, 8'hE9: o = OPD_I32;
                8'h80, 8'h83: begin
                    o = OPD_RM | OPD_I8;
                    h = (reg_f != 3'd2) && (reg_f != 3'd3);
                end
                8'h81: begin
                    o = OPD_RM | OPD_I32;
                    h = (reg_f != 3'd2) && (reg_f != 3'd3);
                end
                [8'h48:8'h4F]: begin
                    o = OPD_LOW3;
                    h = !lm;
                end
                [8'h50:8'h57]: o = OPD_LOW3;
                8'hFE: begin
                    o = OPD_RM;
                    h = reg_f == 3'd1;
                end
                8'hFF: begin
                    o = OPD_RM;
                    h = reg_f == 3'd1 || reg_f == 3'd4 || reg_f == 3'd6;
                end
                8'hCC, 8'hC9, 8'hC3, 8'h06, 8'h0E, 8'h16, 8'h1E: o = '0;
                8'hA0, 8'hA1, 8'hA2, 8'hA3: o = OPD_MOFS;
                [8'hB0:8'hB7]: o = OPD_LOW3 | OPD_I8;
                [8'hB8:8'hBF]: begin
                    o = OPD_LOW3 | OPD_I32;
                    w = 1'b1;
                end
                8'hC6: begin
                    o = OPD_RM | OPD_I8;
                    h = reg_f == 3'd0;
                end
                8'hC7: begin
                    o = OPD_RM | OPD_I32;
                    h = reg_f == 3'd0;
                end
                default: h = 1'b0;
            endcase
        end
        return {h, w, o};
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/xild_prefix.sv
`default_nettype none
module xild_prefix
    import xild_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] window,
    input  wire logic        long_mode,
    output logic             out_valid,
    output logic [63:0]      out_window,
    output xild_pfx_t        out_pfx
);
    xild_pfx_t  pfx_next;
    xild_pfx_t  pfx_reg;
    logic       valid_reg;
    logic [63:0] win_reg;

    always_comb
    begin
        logic       done;
        logic [7:0] b;
        pfx_next = '0;
        done = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            b = window[8*i +: 8];
            if (!done)
            begin
                if (is_seg(b) && !pfx_next.seg)
                begin
                    pfx_next.seg = 1'b1;
                    pfx_next.pos = pfx_next.pos + 3'd1;
                end
                else if (b == BYTE_P66 && !pfx_next.p66)
                begin
                    pfx_next.p66 = 1'b1;
                    pfx_next.pos = pfx_next.pos + 3'd1;
                end
                else if (b == BYTE_P67 && !pfx_next.p67)
                begin
                    pfx_next.p67 = 1'b1;
                    pfx_next.pos = pfx_next.pos + 3'd1;
                end
                else
                begin
                    if (long_mode && b[7:4] == 4'h4)
                    begin
                        pfx_next.rex  = 1'b1;
                        pfx_next.rexw = b[3];
                        pfx_next.pos  = pfx_next.pos + 3'd1;
                    end
                    done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pfx_reg <= pfx_next;
        win_reg <= window;
    end

    assign out_valid  = valid_reg;
    assign out_window = win_reg;
    assign out_pfx    = pfx_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/xild_match.sv
`default_nettype none
module xild_match
    import xild_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] window,
    input  wire xild_pfx_t   pfx,
    input  wire logic        long_mode,
    output logic             out_valid,
    output xild_match_t      out_match
);
    xild_match_t match_next;
    xild_match_t match_reg;
    logic        valid_reg;

    always_comb
    begin
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [8:0]  lk;
        logic [63:0] sh;
        sh = window >> {pfx.pos, 3'b000};
        b0 = sh[7:0];
        b1 = sh[15:8];
        b2 = sh[23:16];
        b3 = sh[31:24];
        match_next = '0;
        match_next.pfx = pfx;
        match_next.twobyte = (b0 == BYTE_ESC);
        match_next.modrm = match_next.twobyte ? b2 : b1;
        match_next.sib   = match_next.twobyte ? b3 : b2;
        lk = op_lookup(match_next.twobyte, b0, b1, match_next.modrm[5:3], long_mode);
        match_next.hit  = lk[8];
        match_next.wide = lk[7];
        match_next.opd  = lk[6:0];
        match_next.rel  = !match_next.twobyte && b0 == BYTE_JREL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign out_valid = valid_reg;
    assign out_match = match_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/xild_size.sv
`default_nettype none
module xild_size
    import xild_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire xild_match_t m,
    input  wire logic        long_mode,
    input  wire logic        wide_moffs,
    output logic             out_valid,
    output xild_res_t        out_res
);
    xild_res_t res_next;
    xild_res_t res_reg;
    logic      valid_reg;

    always_comb
    begin
        logic [1:0] md;
        logic [2:0] rm;
        logic       hm;
        logic       hs;
        logic [3:0] disp;
        logic [3:0] imm;
        logic       fix;
        logic [1:0] ol;
        md = m.modrm[7:6];
        rm = m.modrm[2:0];
        ol = m.twobyte ? 2'd2 : 2'd1;
        hm = |(m.opd & OPD_RMR);
        hs = |(m.opd & OPD_RM) && md != 2'd3 && rm == 3'd4;
        disp = '0;
        imm = '0;
        fix = 1'b0;
        if (|(m.opd & OPD_RM))
        begin
            if (md == 2'd1)
                disp = 4'd1;
            else if (md == 2'd2)
                disp = m.pfx.p66 ? 4'd2 : 4'd4;
            else if (md == 2'd0 && rm == 3'd5)
            begin
                disp = 4'd4;
                fix = long_mode;
            end
            else if (hs && m.sib[2:0] == 3'd5)
                disp = 4'd4;
        end
        if (|(m.opd & OPD_I8))
            imm = 4'd1;
        else if (|(m.opd & OPD_I16))
            imm = 4'd2;
        else if (|(m.opd & OPD_I32))
            imm = (m.wide && m.pfx.rexw) ? 4'd8 : (m.pfx.p66 ? 4'd2 : 4'd4);
        else if (|(m.opd & OPD_MOFS))
            imm = wide_moffs ? (m.pfx.p67 ? 4'd4 : 4'd8) : (m.pfx.p67 ? 4'd2 : 4'd4);
        if (m.rel)
        begin
            fix = 1'b1;
            disp = imm;
            imm = '0;
        end
        res_next = '0;
        if (m.hit)
        begin
            res_next.recognized = 1'b1;
            res_next.prefix_flags = {m.pfx.rex, m.pfx.p67, m.pfx.p66, m.pfx.seg};
            res_next.opcode_length = ol;
            res_next.has_modrm = hm;
            res_next.has_sib = hs;
            res_next.disp_length = disp[2:0];
            res_next.imm_length = imm;
            res_next.disp_needs_fixup = fix;
            res_next.total_length = {1'b0, m.pfx.pos} + {2'b00, ol} + {3'b000, hm}
                                  + {3'b000, hs} + disp + imm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/x86_instruction_length_decoder.sv
// Path: an accepted start passes the prefix, match and size registers, in that order, to the done strobe.
// Throughput: one request per cycle; busy is never raised.
// Stages: prefix scan, opcode match, length sum.
// Reset clears the stage valid bits and both config registers to 0.
// The receiver cannot stall; each result shows for one cycle.
`default_nettype none
module x86_instruction_length_decoder
    import xild_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] instruction_window,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic        cfg_data,
    output logic             done,
    output logic             recognized,
    output logic [3:0]       prefix_flags,
    output logic [1:0]       opcode_length,
    output logic             has_modrm,
    output logic             has_sib,
    output logic [2:0]       disp_length,
    output logic [3:0]       imm_length,
    output logic             disp_needs_fixup,
    output logic [3:0]       total_length
);
    logic        long_mode_reg;
    logic        wide_moffs_reg;
    logic        v1;
    logic        v2;
    logic [63:0] w1;
    xild_pfx_t   p1;
    xild_match_t m2;
    xild_res_t   r3;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg  <= 1'b0;
            wide_moffs_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LONG_MODE:  long_mode_reg  <= cfg_data;
                CFG_WIDE_MOFFS: wide_moffs_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    xild_prefix u_prefix (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .window(instruction_window), .long_mode(long_mode_reg),
        .out_valid(v1), .out_window(w1), .out_pfx(p1)
    );

    xild_match u_match (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .window(w1), .pfx(p1),
        .long_mode(long_mode_reg), .out_valid(v2), .out_match(m2)
    );

    xild_size u_size (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .m(m2),
        .long_mode(long_mode_reg), .wide_moffs(wide_moffs_reg),
        .out_valid(done), .out_res(r3)
    );

    assign recognized       = r3.recognized;
    assign prefix_flags     = r3.prefix_flags;
    assign opcode_length    = r3.opcode_length;
    assign has_modrm        = r3.has_modrm;
    assign has_sib          = r3.has_sib;
    assign disp_length      = r3.disp_length;
    assign imm_length       = r3.imm_length;
    assign disp_needs_fixup = r3.disp_needs_fixup;
    assign total_length     = r3.total_length;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 v2 ##1 done) else $error("request lost in pipe");
    a_zero_unrec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !recognized) |-> (total_length == 4'd0 && prefix_flags == 4'd0))
        else $error("unrecognized result not cleared");
    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        (done && recognized) |-> (opcode_length != 2'd0 && total_length != 4'd0))
        else $error("recognized result has no length");
endmodule
`default_nettype wire

FILE: tb/x86_instruction_length_decoder_checker.sv
module x86_instruction_length_decoder_checker
    import xild_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [63:0] instruction_window,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic        cfg_data,
    input  wire logic        done,
    input  wire logic        recognized,
    input  wire logic [3:0]  prefix_flags,
    input  wire logic [1:0]  opcode_length,
    input  wire logic        has_modrm,
    input  wire logic        has_sib,
    input  wire logic [2:0]  disp_length,
    input  wire logic [3:0]  imm_length,
    input  wire logic        disp_needs_fixup,
    input  wire logic [3:0]  total_length,
    output int               error_count,
    output int               pending_count
);

    xild_res_t layout_queue[$];
    logic      long_mode_q;
    logic      wide_moffs_q;

    function automatic logic [7:0] window_byte(input logic [63:0] w, input int i);
        return w[(i % 8) * 8 +: 8];
    endfunction

    // Independent decode of one instruction window into its layout.
    function automatic xild_res_t decode_layout(input logic [63:0] w, input logic lm,
                                                input logic wm);
        xild_res_t r;
        int  pos, oplen, disp, imm;
        logic seg, p66, p67, rex, rexw, hit, rm_form, reg_form, low3, wide, rel, fix;
        logic i8, i32, mofs;
        logic [7:0] b, op, op2, modrm, sib;
        logic [1:0] md;
        logic [2:0] rg, rm;
        r = '0;
        pos = 0; seg = 0; p66 = 0; p67 = 0; rex = 0; rexw = 0;
        hit = 1; rm_form = 0; reg_form = 0; low3 = 0; wide = 0; rel = 0; fix = 0;
        i8 = 0; i32 = 0; mofs = 0; disp = 0; imm = 0;
        while (pos < 4) begin
            b = window_byte(w, pos);
            if ((b == 8'h2E || b == 8'h36 || b == 8'h26 || b == 8'h64 || b == 8'h65)
                && !seg)
            begin
                seg = 1; pos++; continue;
            end
            if (b == 8'h66 && !p66)
            begin
                p66 = 1; pos++; continue;
            end
            if (b == 8'h67 && !p67)
            begin
                p67 = 1; pos++; continue;
            end
            if (lm && b[7:4] == 4'h4)
            begin
                rex = 1; rexw = b[3]; pos++;
            end
            break;
        end
        op = window_byte(w, pos);
        op2 = window_byte(w, pos + 1);
        oplen = (op == 8'h0F) ? 2 : 1;
        modrm = window_byte(w, pos + oplen);
        sib = window_byte(w, pos + oplen + 1);
        md = modrm[7:6]; rg = modrm[5:3]; rm = modrm[2:0];
        if (oplen == 2)
        begin
            hit = op2 == 8'hB6 || op2 == 8'hB7;
            rm_form = 1; reg_form = 1;
        end
        else if ((op[7:6] == 2'b00 && op[2] == 1'b0 && op[5:3] inside {0, 1, 4, 5, 6, 7})
                 || op inside {8'h8D, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E})
        begin
            rm_form = 1; reg_form = 1;
        end
        else if (op[7:6] == 2'b00 && op[2:0] == 3'd4 && op[5:3] inside {0, 1, 4, 5, 6, 7})
            i8 = 1;
        else if (op[7:6] == 2'b00 && op[2:0] == 3'd5 && op[5:3] inside {0, 1, 4, 5, 6, 7})
            i32 = 1;
        else if (op == 8'h6A) i8 = 1;
        else if (op == 8'h68) i32 = 1;
        else if (op == 8'hE9)
        begin
            i32 = 1; rel = 1;
        end
        else if (op == 8'h80 || op == 8'h83 || op == 8'h81)
        begin
            rm_form = 1; i8 = op != 8'h81; i32 = op == 8'h81;
            hit = rg != 2 && rg != 3;
        end
        else if (op[7:3] == 5'b01001)
        begin
            low3 = 1; hit = !lm;
        end
        else if (op[7:3] == 5'b01010) low3 = 1;
        else if (op == 8'hFE)
        begin
            rm_form = 1; hit = rg == 1;
        end
        else if (op == 8'hFF)
        begin
            rm_form = 1; hit = rg == 1 || rg == 4 || rg == 6;
        end
        else if (op inside {8'hCC, 8'hC9, 8'hC3, 8'h06, 8'h0E, 8'h16, 8'h1E}) hit = 1;
        else if (op inside {8'hA0, 8'hA1, 8'hA2, 8'hA3}) mofs = 1;
        else if (op[7:3] == 5'b10110) i8 = 1;
        else if (op[7:3] == 5'b10111)
        begin
            i32 = 1; wide = 1;
        end
        else if (op == 8'hC6 || op == 8'hC7)
        begin
            rm_form = 1; i8 = op == 8'hC6; i32 = op == 8'hC7; hit = rg == 0;
        end
        else hit = 0;
        if (!hit) return r;
        r.has_modrm = rm_form || reg_form;
        r.has_sib = rm_form && md != 3 && rm == 4;
        if (rm_form)
        begin
            if (md == 1) disp = 1;
            else if (md == 2) disp = p66 ? 2 : 4;
            else if (md == 0 && rm == 5)
            begin
                disp = 4; fix = lm;
            end
            else if (r.has_sib && sib[2:0] == 5) disp = 4;
        end
        if (i8) imm = 1;
        else if (i32) imm = (wide && rexw) ? 8 : (p66 ? 2 : 4);
        else if (mofs) imm = wm ? (p67 ? 4 : 8) : (p67 ? 2 : 4);
        if (rel)
        begin
            fix = 1; disp = imm; imm = 0;
        end
        r.recognized = 1;
        r.prefix_flags = {rex, p67, p66, seg};
        r.opcode_length = 2'(oplen);
        r.disp_length = 3'(disp);
        r.imm_length = 4'(imm);
        r.disp_needs_fixup = fix;
        r.total_length = 4'(pos + oplen + r.has_modrm + r.has_sib + disp + imm);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    assign pending_count = layout_queue.size();

    initial error_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        xild_res_t want;
        if (!rst_n)
        begin
            long_mode_q <= 1'b0;
            wide_moffs_q <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (layout_queue.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = layout_queue.pop_front();
                    if (recognized !== want.recognized)
                        report_mismatch("recognized", recognized, want.recognized);
                    if (prefix_flags !== want.prefix_flags)
                        report_mismatch("prefix_flags", prefix_flags, want.prefix_flags);
                    if (opcode_length !== want.opcode_length)
                        report_mismatch("opcode_length", opcode_length, want.opcode_length);
                    if (has_modrm !== want.has_modrm)
                        report_mismatch("has_modrm", has_modrm, want.has_modrm);
                    if (has_sib !== want.has_sib)
                        report_mismatch("has_sib", has_sib, want.has_sib);
                    if (disp_length !== want.disp_length)
                        report_mismatch("disp_length", disp_length, want.disp_length);
                    if (imm_length !== want.imm_length)
                        report_mismatch("imm_length", imm_length, want.imm_length);
                    if (disp_needs_fixup !== want.disp_needs_fixup)
                        report_mismatch("disp_needs_fixup", disp_needs_fixup,
                                        want.disp_needs_fixup);
                    if (total_length !== want.total_length)
                        report_mismatch("total_length", total_length, want.total_length);
                end
            end
            if (start && !busy)
                layout_queue.push_back(decode_layout(instruction_window, long_mode_q,
                                                     wide_moffs_q));
            if (cfg_we && cfg_index == CFG_LONG_MODE) long_mode_q <= cfg_data;
            if (cfg_we && cfg_index == CFG_WIDE_MOFFS) wide_moffs_q <= cfg_data;
        end
    end

endmodule

FILE: tb/x86_instruction_length_decoder_tb.sv
module x86_instruction_length_decoder_tb;
    import xild_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] instruction_window;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic        cfg_data;
    logic        done;
    logic        recognized;
    logic [3:0]  prefix_flags;
    logic [1:0]  opcode_length;
    logic        has_modrm;
    logic        has_sib;
    logic [2:0]  disp_length;
    logic [3:0]  imm_length;
    logic        disp_needs_fixup;
    logic [3:0]  total_length;
    int          error_count;
    int          pending_count;
    bit          no_gaps;

    // opcodes worth hitting: table members plus a few near misses
    localparam logic [7:0] OPCODE_POOL[48] = '{
        8'h00, 8'h03, 8'h04, 8'h05, 8'h0B, 8'h0C, 8'h0D, 8'h21, 8'h25, 8'h2A,
        8'h34, 8'h3D, 8'h80, 8'h81, 8'h83, 8'h82, 8'h48, 8'h4F, 8'h50, 8'h57,
        8'hFE, 8'hFF, 8'hCC, 8'hC9, 8'hC3, 8'hE9, 8'h8D, 8'h88, 8'h8B, 8'h8C,
        8'h8E, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hB0, 8'hB7, 8'hB8, 8'hBF, 8'hC6,
        8'hC7, 8'h0F, 8'h06, 8'h1E, 8'h68, 8'h6A, 8'h90, 8'h8F
    };
    localparam logic [7:0] PREFIX_POOL[8] = '{
        8'h2E, 8'h36, 8'h26, 8'h64, 8'h65, BYTE_P66, BYTE_P67, 8'h48
    };

    x86_instruction_length_decoder u_dut (.*);
    x86_instruction_length_decoder_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // start stays high between back-to-back requests; it drops only while idling
    task automatic send_window(input logic [63:0] w);
        if (!no_gaps)
            while ($urandom_range(99) < 13)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        start <= 1'b1;
        instruction_window <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        start <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_mode(input logic lm, input logic wm);
        drain_and_settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_LONG_MODE;
        cfg_data <= lm;
        @(negedge clk);
        cfg_index <= CFG_WIDE_MOFFS;
        cfg_data <= wm;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] shaped_window();
        logic [63:0] w;
        int n;
        w = {$urandom, $urandom};
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
            w[i*8 +: 8] = PREFIX_POOL[$urandom_range(7)];
        if ($urandom_range(9) == 0)
            w[n*8 +: 8] = 8'h40 | 8'($urandom_range(15));
        else
        begin
            w[n*8 +: 8] = OPCODE_POOL[$urandom_range(47)];
            if (w[n*8 +: 8] == BYTE_ESC)
                w[(n+1)*8 +: 8] = $urandom_range(1) ? 8'hB6 : 8'hB7;
        end
        return w;
    endfunction

    initial
    begin
        #400000;
        $display("** x86_instruction_length_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        start = 1'b0;
        instruction_window = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_LONG_MODE;
        cfg_data = 1'b0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed cases
        send_window(64'h0);
        send_window('1);
        send_window(64'h0000_0000_0005_6626);           // seg + 66 + add eax,imm
        send_window(64'h0000_0000_0000_6666);           // repeated 66 as opcode
        send_window(64'h0000_0000_0000_0048);           // dec in 32-bit mode
        send_window(64'h0000_0000_0025_0403);           // sib base 101 mod 00
        send_window(64'h0000_0000_0000_8081);           // mod 10 disp32 + imm32
        send_window(64'h0000_0000_8066_8166);
        send_window(64'h0000_0000_0000_0005);
        send_window(64'h0000_0000_0000_05E9);
        send_window(64'h0000_0000_0000_E966);
        send_window(64'h0000_0000_00C0_B60F);
        send_window(64'h0000_0000_0000_A167);
        send_window(64'h0000_0000_0000_18FF);           // ff /3 not supported
        write_mode(1'b1, 1'b1);
        send_window(64'h0000_0000_0000_B848);           // rex.w mov imm64
        send_window(64'h0000_0000_0000_B840);           // rex without w
        send_window(64'h0000_0000_0000_0048);
        send_window(64'h0000_0000_0005_8B48);           // rip-relative
        send_window(64'h0000_0000_0000_A167);
        send_window(64'h0000_0000_0000_00A0);
        send_window(64'h0000_00B8_4867_6626);
        write_mode(1'b0, 1'b1);
        send_window(64'h0000_0000_0000_00A3);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0], phase[1]);
            no_gaps = phase == 2;
            for (int i = 0; i < 220; i++)
                send_window(($urandom_range(9) < 8) ? shaped_window() : {$urandom, $urandom});
        end

        drain_and_settle();
        if (error_count == 0)
            $display("** x86_instruction_length_decoder: PASSED **");
        else
            $display("** x86_instruction_length_decoder: FAILED **");
        $finish;
    end

endmodule

FILE: x86_instruction_length_decoder.f
hw/rtl/xild_pkg.sv
hw/rtl/xild_prefix.sv
hw/rtl/xild_match.sv
hw/rtl/xild_size.sv
hw/rtl/x86_instruction_length_decoder.sv
tb/x86_instruction_length_decoder_checker.sv
tb/x86_instruction_length_decoder_tb.sv
